FILE: hw/rtl/dvrt_pkg.sv
// shared types, constants and entry update functions of the distance-vector route table
package dvrt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 8;
    localparam logic [4:0] METRIC_INF = 5'd16;
    localparam logic [4:0] METRIC_ONE = 5'd1;

    typedef enum logic [1:0] {
        KIND_ADVERT  = 2'd0,
        KIND_UNREACH = 2'd1,
        KIND_REACH   = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_MATCH  = 2'd0,
        STATUS_INSERT = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        HOP_DIRECT = 2'd0,
        HOP_VIA    = 2'd1,
        HOP_NONE   = 2'd2
    } hop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_MISS,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0] dest;
        hop_t       hop;
        logic [7:0] router;
        logic [4:0] metric;
    } route_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] dest;
        logic [4:0] adv;
        logic [7:0] sender;
        logic [2:0] ridx;
        logic       last;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [2:0] index;
        logic [7:0] dest;
        hop_t       hop;
        logic [7:0] router;
        logic [4:0] metric;
        logic [3:0] count;
        logic       done;
    } result_t;

    // sender's metric plus one, capped when stored
    function automatic logic [4:0] cap_metric(logic [5:0] cand);
        return (cand > 6'(METRIC_INF)) ? METRIC_INF : cand[4:0];
    endfunction

    function automatic route_t route_update(route_t e, item_t it);
        route_t     r;
        logic [5:0] cand;
        logic [4:0] capped;
        r      = e;
        cand   = {1'b0, it.adv} + 6'd1;
        capped = cap_metric(cand);
        case (it.kind)
            KIND_ADVERT:
            begin
                if (e.hop != HOP_DIRECT)
                begin
                    if ({1'b0, e.metric} > cand)
                    begin
                        r.metric = capped;
                        r.hop    = HOP_VIA;
                        r.router = it.sender;
                    end
                    if (r.hop == HOP_VIA && r.router == it.sender && {1'b0, e.metric} != cand)
                    begin
                        r.metric = capped;
                    end
                end
            end
            KIND_UNREACH:
            begin
                r.metric = METRIC_INF;
            end
            KIND_REACH:
            begin
                r.metric = METRIC_ONE;
                r.hop    = HOP_DIRECT;
                r.router = 8'd0;
            end
            default:
            begin
                r = e;
            end
        endcase
        return r;
    endfunction

    function automatic route_t route_new(item_t it);
        route_t r;
        r.dest = it.dest;
        case (it.kind)
            KIND_ADVERT:
            begin
                r.hop    = HOP_VIA;
                r.router = it.sender;
                r.metric = cap_metric({1'b0, it.adv} + 6'd1);
            end
            KIND_UNREACH:
            begin
                r.hop    = HOP_NONE;
                r.router = 8'd0;
                r.metric = METRIC_INF;
            end
            default:
            begin
                r.hop    = HOP_DIRECT;
                r.router = 8'd0;
                r.metric = METRIC_ONE;
            end
        endcase
        return r;
    endfunction

    // result beat for one entry; router shows only on via routes
    function automatic result_t make_result(route_t e, status_t st, logic [2:0] idx,
                                            logic last);
        result_t r;
        r.status = st;
        r.index  = idx;
        r.dest   = e.dest;
        r.hop    = e.hop;
        r.router = (e.hop == HOP_VIA) ? e.router : 8'd0;
        r.metric = e.metric;
        r.count  = 4'd0;
        r.done   = last;
        return r;
    endfunction

endpackage

FILE: hw/rtl/dvrt_if.sv
// request and response channel interfaces of the route table
interface dvrt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] destination;
    logic [4:0] advertised_metric;
    logic [7:0] sender;
    logic [2:0] read_index;
    logic       advert_last;

    modport source (
        output valid, kind, destination, advertised_metric, sender, read_index, advert_last,
        input  ready
    );
    modport sink (
        input  valid, kind, destination, advertised_metric, sender, read_index, advert_last,
        output ready
    );
endinterface

interface dvrt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] entry_index;
    logic [7:0] entry_destination;
    logic [1:0] hop_kind;
    logic [7:0] next_router;
    logic [4:0] entry_metric;
    logic [3:0] entry_count;
    logic       advert_done;

    modport source (
        output valid, status, entry_index, entry_destination, hop_kind, next_router,
               entry_metric, entry_count, advert_done,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, entry_destination, hop_kind, next_router,
               entry_metric, entry_count, advert_done,
        output ready
    );
endinterface

FILE: hw/rtl/dvrt_mem.sv
// route entry memory, one write and one registered read port
module dvrt_mem
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output route_t           rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  route_t           wr_data
);

    route_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/dvrt_ctrl.sv
// sequencer: reads or scans the table, updates or appends one entry, holds the result beat
module dvrt_ctrl
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int CMP_W = (CNT_W > 3) ? CNT_W : 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    dvrt_req_if.sink         req,
    dvrt_rsp_if.source       rsp,
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_addr,
    input  route_t           rd_data,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_addr,
    output route_t           wr_data
);

    state_t           state_reg, state_next;
    item_t            item_reg, item_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] used_reg, used_next;
    result_t          res_reg, res_next;
    result_t          out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    item_t  in_item;
    route_t upd_entry;
    route_t new_entry;
    logic   ridx_ok;

    assign in_item.kind   = kind_t'(req.kind);
    assign in_item.dest   = req.destination;
    assign in_item.adv    = req.advertised_metric;
    assign in_item.sender = req.sender;
    assign in_item.ridx   = req.read_index;
    assign in_item.last   = req.advert_last;

    assign ridx_ok   = CMP_W'(req.read_index) < CMP_W'(used_reg);
    assign upd_entry = route_update(rd_data, item_reg);
    assign new_entry = route_new(item_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        scan_reg <= scan_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        scan_next      = scan_reg;
        used_next      = used_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_reg;
        wr_en          = 1'b0;
        wr_addr        = scan_reg;
        wr_data        = upd_entry;
        req.ready      = (state_reg == ST_IDLE);

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    item_next = in_item;
                    if (in_item.kind == KIND_READ)
                    begin
                        if (ridx_ok)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = IDX_W'(req.read_index);
                            state_next = ST_READ;
                        end
                        else
                        begin
                            res_next        = '0;
                            res_next.status = STATUS_EMPTY;
                            res_next.index  = req.read_index;
                            res_next.done   = req.advert_last;
                            state_next      = ST_FINISH;
                        end
                    end
                    else if (used_reg == '0)
                    begin
                        state_next = ST_MISS;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        scan_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_READ:
            begin
                res_next   = make_result(rd_data, STATUS_MATCH, item_reg.ridx, item_reg.last);
                state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (rd_data.dest == item_reg.dest)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = scan_reg;
                    wr_data    = upd_entry;
                    res_next   = make_result(upd_entry, STATUS_MATCH, 3'(scan_reg),
                                             item_reg.last);
                    state_next = ST_FINISH;
                end
                else if ((CNT_W'(scan_reg) + CNT_W'(1)) < used_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = scan_reg + IDX_W'(1);
                    scan_next  = scan_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS:
            begin
                if (used_reg >= CNT_W'(TABLE_DEPTH))
                begin
                    res_next        = '0;
                    res_next.status = STATUS_FULL;
                    res_next.dest   = item_reg.dest;
                    res_next.done   = item_reg.last;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_addr   = IDX_W'(used_reg);
                    wr_data   = new_entry;
                    used_next = used_reg + CNT_W'(1);
                    res_next  = make_result(new_entry, STATUS_INSERT, 3'(used_reg),
                                            item_reg.last);
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_next.count = 4'(used_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_reg.status;
    assign rsp.entry_index       = out_reg.index;
    assign rsp.entry_destination = out_reg.dest;
    assign rsp.hop_kind          = out_reg.hop;
    assign rsp.next_router       = out_reg.router;
    assign rsp.entry_metric      = out_reg.metric;
    assign rsp.entry_count       = out_reg.count;
    assign rsp.advert_done       = out_reg.done;

endmodule

FILE: hw/rtl/distance_vector_route_table.sv
// top level of the distance-vector route table
// The table keeps up to TABLE_DEPTH routes (destination, hop kind, next router, metric 1..16,
// where 16 is unreachable) in a single-port-read memory, and handles one request beat at a
// time, giving exactly one response beat for each. An advertised entry updates a matching
// route (never a direct one) or is appended with its metric plus one, capped at 16; set
// unreachable and set reachable update or append; a read returns the entry at read_index.
// A request that searches walks the used entries one memory read per cycle, from position 0
// upward: a hit stops the walk, a miss ends it after the last used entry (straight away
// when the table is empty), and a read does one memory read, or none when read_index is
// not below the entry count. The walk is serial, set by the one read port of the entry
// memory. The next request can be taken in the cycle after the response is loaded.
// The response sits
// in an output register, so a stalled response does not block the next request from being
// taken. Every access to an entry is finished before the next request is accepted, so reads
// never overlap a pending write. No clearing pass is needed after reset: only positions below
// the entry count are ever read.
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic       clk,
    input  logic       rst_n,
    dvrt_req_if.sink   req,
    dvrt_rsp_if.source rsp
);

    // memory port signals between sequencer and entry store
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    route_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    route_t           wr_data;

    // sequencer: accept, scan, update or append, response register
    dvrt_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    // entry store, registered read port
    dvrt_mem #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_mem (
        .clk    (clk),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data)
    );

    // a write-back never shares a cycle with a read
    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("memory read and write in the same cycle");

    // the table is never written while a new request beat is taken
    a_no_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !wr_en)
        else $error("memory write while accepting a request");

    // a request is taken only after the previous one left the sequencer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while one is in flight");

    // router id shows only on via routes
    a_router_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hop_kind != HOP_VIA) |-> rsp.next_router == 8'd0)
        else $error("next router set on a route that is not via a router");

    // stored metrics stay within 1..16
    a_metric_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == STATUS_MATCH || rsp.status == STATUS_INSERT))
        |-> (rsp.entry_metric >= METRIC_ONE && rsp.entry_metric <= METRIC_INF))
        else $error("entry metric out of range");

endmodule

FILE: tb/route_table_checker.sv
// route table checker: predicts each reply beat from the request beats and compares
`timescale 1ns / 1ps

module route_table_checker
    import dvrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dvrt_req_if         req_ch,
    dvrt_rsp_if         rsp_ch,
    output int unsigned fail_count,
    output int unsigned pending_count
);

    localparam int ROUTE_SLOTS = DEFAULT_TABLE_DEPTH;
    localparam int REPORT_LIMIT = 10;

    route_t     routes [ROUTE_SLOTS] = '{default: '0};
    logic [3:0] route_count = '0;
    result_t    predicted_replies [$];

    // reply for a stored entry; router shows only on via routes
    function automatic result_t entry_reply(status_t st, logic [2:0] idx, logic last);
        result_t r;
        r.status = st;
        r.index  = idx;
        r.dest   = routes[idx].dest;
        r.hop    = routes[idx].hop;
        r.router = (routes[idx].hop == HOP_VIA) ? routes[idx].router : 8'd0;
        r.metric = routes[idx].metric;
        r.count  = route_count;
        r.done   = last;
        return r;
    endfunction

    // applies one request beat to the table copy and returns the reply it causes
    function automatic result_t update_route_table(item_t it);
        result_t    r;
        logic [5:0] cand_metric;
        logic [4:0] kept_dist;
        logic [5:0] old_metric;
        int         slot;
        r           = '0;
        r.done      = it.last;
        cand_metric = {1'b0, it.adv} + 6'd1;
        kept_dist   = (cand_metric > 6'(METRIC_INF)) ? METRIC_INF : cand_metric[4:0];

        if (it.kind == KIND_READ)
        begin
            if (it.ridx < route_count)
                return entry_reply(STATUS_MATCH, it.ridx, it.last);
            r.status = STATUS_EMPTY;
            r.index  = it.ridx;
            r.count  = route_count;
            return r;
        end

        slot = -1;
        for (int i = 0; i < ROUTE_SLOTS; i++)
        begin
            if (slot < 0 && i < route_count && routes[i].dest == it.dest)
                slot = i;
        end

        if (slot >= 0)
        begin
            case (it.kind)
                KIND_ADVERT:
                begin
                    // direct routes never follow adverts
                    if (routes[slot].hop != HOP_DIRECT)
                    begin
                        old_metric = {1'b0, routes[slot].metric};
                        if (old_metric > cand_metric)
                        begin
                            routes[slot].metric = kept_dist;
                            routes[slot].hop    = HOP_VIA;
                            routes[slot].router = it.sender;
                        end
                        if (routes[slot].hop == HOP_VIA && routes[slot].router == it.sender
                            && old_metric != cand_metric)
                            routes[slot].metric = kept_dist;
                    end
                end
                KIND_UNREACH:
                begin
                    routes[slot].metric = METRIC_INF;
                end
                default:
                begin
                    routes[slot].metric = METRIC_ONE;
                    routes[slot].hop    = HOP_DIRECT;
                    routes[slot].router = 8'd0;
                end
            endcase
            return entry_reply(STATUS_MATCH, 3'(slot), it.last);
        end

        if (route_count >= ROUTE_SLOTS)
        begin
            r.status = STATUS_FULL;
            r.dest   = it.dest;
            r.count  = route_count;
            return r;
        end

        slot = route_count;
        routes[slot].dest = it.dest;
        case (it.kind)
            KIND_ADVERT:
            begin
                routes[slot].hop    = HOP_VIA;
                routes[slot].router = it.sender;
                routes[slot].metric = kept_dist;
            end
            KIND_UNREACH:
            begin
                routes[slot].hop    = HOP_NONE;
                routes[slot].router = 8'd0;
                routes[slot].metric = METRIC_INF;
            end
            default:
            begin
                routes[slot].hop    = HOP_DIRECT;
                routes[slot].router = 8'd0;
                routes[slot].metric = METRIC_ONE;
            end
        endcase
        route_count = route_count + 4'd1;
        return entry_reply(STATUS_INSERT, 3'(slot), it.last);
    endfunction

    function automatic string reply_text(result_t r);
        return $sformatf("st=%0d idx=%0d dst=%0d hop=%0d rtr=%0d met=%0d cnt=%0d done=%0d",
                         r.status, r.index, r.dest, r.hop, r.router, r.metric, r.count, r.done);
    endfunction

    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            route_count = '0;
            predicted_replies.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            // reply beats first: a request taken at this edge cannot answer at it
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen = {rsp_ch.status, rsp_ch.entry_index, rsp_ch.entry_destination,
                        rsp_ch.hop_kind, rsp_ch.next_router, rsp_ch.entry_metric,
                        rsp_ch.entry_count, rsp_ch.advert_done};
                if (predicted_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected route reply: %s", reply_text(seen));
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("route reply mismatch: expected %s, got %s",
                                     reply_text(want), reply_text(seen));
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                predicted_replies.push_back(update_route_table({req_ch.kind,
                    req_ch.destination, req_ch.advertised_metric, req_ch.sender,
                    req_ch.read_index, req_ch.advert_last}));
            pending_count = predicted_replies.size();
        end
    end

endmodule

FILE: tb/distance_vector_route_table_test.sv
// top of the route table test: clock, reset, request stimulus, reply stalls and verdict
`timescale 1ns / 1ps

module distance_vector_route_table_test;
    import dvrt_pkg::*;

    localparam int          ITEMS_PER_PHASE  = 275;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_LIMIT      = 20000;
    localparam int unsigned SETTLE_CYCLES    = 24;
    localparam longint      RUN_LIMIT_NS     = 3_000_000;

    // idle and stall odds per random phase, in percent
    localparam int unsigned PHASE_IDLE  [4] = '{0, 76, 0, 17};
    localparam int unsigned PHASE_STALL [4] = '{0, 0, 76, 17};

    // destinations the directed part leaves in the table, in table order;
    // positions 1 and 2 hold the direct routes
    localparam logic [7:0] TABLE_DESTS [8] = '{8'd0, 8'd255, 8'd170, 8'd85,
                                               8'd1, 8'd2, 8'd3, 8'd4};
    // a few neighbours so that the next hop often repeats
    localparam logic [7:0] NEIGHBOURS [4] = '{8'd7, 8'd9, 8'd200, 8'd3};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request beat as driven, known from time zero
    logic       req_valid  = 1'b0;
    logic [1:0] req_kind   = '0;
    logic [7:0] req_dest   = '0;
    logic [4:0] req_metric = 5'd1;
    logic [7:0] req_sender = '0;
    logic [2:0] req_index  = '0;
    logic       req_last   = 1'b0;
    logic       rsp_ready  = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    bit          hold_request  = 1'b0;
    bit          hold_done     = 1'b0;
    int unsigned hold_left     = 0;

    int unsigned fail_count;
    int unsigned pending_count;

    dvrt_req_if route_req ();
    dvrt_rsp_if route_rsp ();

    assign route_req.valid             = req_valid;
    assign route_req.kind              = req_kind;
    assign route_req.destination       = req_dest;
    assign route_req.advertised_metric = req_metric;
    assign route_req.sender            = req_sender;
    assign route_req.read_index        = req_index;
    assign route_req.advert_last       = req_last;
    assign route_rsp.ready             = rsp_ready;

    distance_vector_route_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (route_req),
        .rsp   (route_rsp)
    );

    route_table_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_ch        (route_req),
        .rsp_ch        (route_rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // reply side: random stalls, plus one long hold-off counted here so that
    // the output register fills and the request side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_done)
        begin
            rsp_ready <= 1'b0;
            hold_left <= LONG_HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // offers one request beat, with random idle cycles ahead of it, and
    // returns at the edge where it is taken
    task automatic offer_route_item(input kind_t k, input logic [7:0] d, input logic [4:0] m,
                                    input logic [7:0] s, input logic [2:0] ri, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_kind   <= k;
        req_dest   <= d;
        req_metric <= m;
        req_sender <= s;
        req_index  <= ri;
        req_last   <= lst;
        do
            @(posedge clk);
        while (!route_req.ready);
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned guard;
        logic [7:0]  d;
        logic [7:0]  s;
        kind_t       k;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads of an empty table, lowest and highest position
        offer_route_item(KIND_READ, 8'd0, 5'd1, 8'd0, 3'd0, 1'b0);
        offer_route_item(KIND_READ, 8'd255, 5'd16, 8'd255, 3'd7, 1'b1);
        // advert of an unreachable network: stored metric capped at 16
        offer_route_item(KIND_ADVERT, 8'd0, 5'd16, 8'd255, 3'd0, 1'b1);
        // shorter path through a new neighbour is adopted
        offer_route_item(KIND_ADVERT, 8'd0, 5'd1, 8'd7, 3'd0, 1'b0);
        // current next hop gets worse: the route follows
        offer_route_item(KIND_ADVERT, 8'd0, 5'd5, 8'd7, 3'd0, 1'b0);
        offer_route_item(KIND_ADVERT, 8'd0, 5'd3, 8'd9, 3'd0, 1'b0);
        offer_route_item(KIND_ADVERT, 8'd0, 5'd15, 8'd9, 3'd0, 1'b0);
        // next hop says unreachable: candidate 17 compared uncapped, stored as 16
        offer_route_item(KIND_ADVERT, 8'd0, 5'd16, 8'd9, 3'd0, 1'b1);
        // unknown network marked unreachable: appended with no next hop
        offer_route_item(KIND_UNREACH, 8'd255, 5'd1, 8'd0, 3'd0, 1'b0);
        // a route with no next hop is not direct, so an advert replaces it
        offer_route_item(KIND_ADVERT, 8'd255, 5'd4, 8'd200, 3'd0, 1'b0);
        offer_route_item(KIND_REACH, 8'd255, 5'd1, 8'd0, 3'd0, 1'b0);
        // direct route ignores a better advert
        offer_route_item(KIND_ADVERT, 8'd255, 5'd1, 8'd3, 3'd0, 1'b0);
        // unreachable keeps the direct hop kind
        offer_route_item(KIND_UNREACH, 8'd255, 5'd1, 8'd0, 3'd0, 1'b0);
        offer_route_item(KIND_REACH, 8'd170, 5'd1, 8'd0, 3'd0, 1'b0);
        offer_route_item(KIND_UNREACH, 8'd0, 5'd1, 8'd0, 3'd0, 1'b0);
        // reads of used positions and of the first free one
        offer_route_item(KIND_READ, 8'd0, 5'd1, 8'd0, 3'd0, 1'b0);
        offer_route_item(KIND_READ, 8'd0, 5'd1, 8'd0, 3'd1, 1'b0);
        offer_route_item(KIND_READ, 8'd0, 5'd1, 8'd0, 3'd2, 1'b0);
        offer_route_item(KIND_READ, 8'd0, 5'd1, 8'd0, 3'd3, 1'b1);
        // fill the table
        offer_route_item(KIND_ADVERT, 8'd85, 5'd3, 8'd3, 3'd0, 1'b0);
        offer_route_item(KIND_ADVERT, 8'd1, 5'd2, 8'd7, 3'd0, 1'b0);
        offer_route_item(KIND_ADVERT, 8'd2, 5'd6, 8'd9, 3'd0, 1'b0);
        offer_route_item(KIND_ADVERT, 8'd3, 5'd10, 8'd200, 3'd0, 1'b0);
        offer_route_item(KIND_ADVERT, 8'd4, 5'd14, 8'd3, 3'd0, 1'b1);
        // full table drops a new network
        offer_route_item(KIND_ADVERT, 8'd128, 5'd2, 8'd7, 3'd0, 1'b1);

        // random part: mostly adverts for known networks from a few neighbours,
        // with reads, unreachable marks, reachable marks kept to the direct
        // routes, and unknown networks that hit the full table
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = PHASE_IDLE[p];
            rcv_stall_pct = PHASE_STALL[p];
            if (p == 0)
                hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(99);
                s = ($urandom_range(99) < 80) ? NEIGHBOURS[$urandom_range(3)] : 8'($urandom());
                d = TABLE_DESTS[$urandom_range(7)];
                if (pick < 10)
                begin
                    k = KIND_READ;
                end
                else if (pick < 15)
                begin
                    k = kind_t'($urandom_range(2));
                    d = 8'($urandom());
                end
                else if (pick < 22)
                begin
                    k = KIND_UNREACH;
                end
                else if (pick < 25)
                begin
                    k = KIND_REACH;
                    d = TABLE_DESTS[1 + $urandom_range(1)];
                end
                else
                begin
                    k = KIND_ADVERT;
                end
                offer_route_item(k, d, 5'($urandom_range(16, 1)), s, 3'($urandom_range(7)),
                                 1'($urandom_range(1)));
            end
        end
        req_valid <= 1'b0;
        send_idle_pct = 0;
        rcv_stall_pct = 0;

        // drain, then give a stray beat time to show up
        guard = 0;
        @(posedge clk);
        while (pending_count != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("distance_vector_route_table_test passed");
        else
            $display("distance_vector_route_table_test failed");
        $finish;
    end

    // hang guard
    initial
    begin
        #RUN_LIMIT_NS;
        $display("distance_vector_route_table_test failed");
        $finish;
    end

endmodule
